FILE: hdl/ltkm_pkg.sv
// shared types, widths and codes for the loser tree k-way merge unit
package ltkm_pkg;

  // tree size
  localparam int MAX_RUNS = 16;
  localparam int FLAG_W   = MAX_RUNS + 1;
  localparam int IDX_W    = $clog2(MAX_RUNS + 1);
  localparam int NODE_W   = $clog2(MAX_RUNS);

  // field widths
  localparam int OP_W    = 2;
  localparam int RUN_W   = 4;
  localparam int HASH_W  = 23;
  localparam int COUNT_W = 16;
  localparam int DOC_W   = 24;
  localparam int CFG_W   = 5;

  localparam logic [HASH_W-1:0] END_MARK = 23'h7FFFFF;

  // op codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD  = 2'd1;
  localparam logic [OP_W-1:0] OP_REFILL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [RUN_W-1:0]   run_index;
    logic [HASH_W-1:0]  key_hash;
    logic [COUNT_W-1:0] word_count;
    logic [DOC_W-1:0]   doc_id;
    logic               run_exhausted;
  } in_beat_t;

  typedef struct packed {
    logic [RUN_W-1:0]   winner_run;
    logic [HASH_W-1:0]  winner_hash;
    logic [COUNT_W-1:0] winner_count;
    logic [DOC_W-1:0]   winner_doc;
    logic               merge_done;
  } out_beat_t;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [COUNT_W-1:0] count;
    logic [DOC_W-1:0]   doc;
  } leaf_rec_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [IDX_W-1:0]  data;
  } loser_wr_t;

endpackage

FILE: hdl/ltkm_loser_ram.sv
// loser node store: one write and one registered read port, entries read as sentinel until written
module ltkm_loser_ram (
  input  logic                        clk,
  input  logic                        rst,
  input  ltkm_pkg::loser_wr_t         wr,
  input  logic [ltkm_pkg::NODE_W-1:0] raddr,
  output logic [ltkm_pkg::IDX_W-1:0]  rdata
);

  logic [ltkm_pkg::IDX_W-1:0]    mem [0:ltkm_pkg::MAX_RUNS-1];
  logic [ltkm_pkg::MAX_RUNS-1:0] written;
  logic [ltkm_pkg::IDX_W-1:0]    rd_q;
  logic                          rd_written;

  // storage array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[raddr];
  end

  // per-entry written flags, read alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      rd_written <= written[raddr];
    end
  end

  // unwritten entries point at the sentinel leaf
  assign rdata = rd_written ? rd_q : ltkm_pkg::IDX_W'(ltkm_pkg::MAX_RUNS);

endmodule

FILE: hdl/loser_tree_kway_merge_unit.sv
// loser tree k-way merge unit: leaf store, replay sequencer and result register
// op 0 (load) keeps busy low. op 2 (refill) keeps busy while it replays one path, which has
// 4 tree levels with 16 runs; the strobe comes as busy drops unless node 0 holds a sentinel.
// op 1 (build) keeps busy while it fills the loser nodes and replays the k leaves. each replay is a
// three-stage pipe (loser node read, leaf read, compare and write back), one level a cycle.
// reset: sentinel bits cleared, loser nodes read as sentinel, runs_in_use = 16, leaves undefined
module loser_tree_kway_merge_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  ltkm_pkg::in_beat_t         cmd,
  output logic                       result_strobe,
  output ltkm_pkg::out_beat_t        result,
  input  logic                       runs_we,
  input  logic [ltkm_pkg::CFG_W-1:0] runs_wdata
);

  typedef enum logic [2:0] {IDLE, FILL, RD_WIN, SEED, REPLAY} state_t;

  state_t                          state;
  logic [ltkm_pkg::CFG_W-1:0]      runs_in_use;
  logic [ltkm_pkg::IDX_W-1:0]      kc;
  ltkm_pkg::in_beat_t              cmd_q;
  logic                            is_build;
  logic [ltkm_pkg::NODE_W-1:0]     fill_cnt;
  logic [ltkm_pkg::IDX_W-1:0]      seed_idx;
  logic [ltkm_pkg::FLAG_W-1:0]     sent_flags;

  // carried leaf moving up the path
  logic [ltkm_pkg::IDX_W-1:0]      cur_idx;
  ltkm_pkg::leaf_rec_t             cur_rec;
  logic                            cur_sent;

  // replay pipe
  logic [ltkm_pkg::NODE_W-1:0]     issue_node;
  logic                            s1_v;
  logic [ltkm_pkg::NODE_W-1:0]     s1_node;
  logic                            s2_v;
  logic [ltkm_pkg::NODE_W-1:0]     s2_node;
  logic [ltkm_pkg::IDX_W-1:0]      s2_idx;

  // memory ports
  ltkm_pkg::leaf_rec_t             leaf_mem [0:ltkm_pkg::MAX_RUNS];
  logic                            leaf_we;
  logic [ltkm_pkg::IDX_W-1:0]      leaf_waddr;
  ltkm_pkg::leaf_rec_t             leaf_wdata;
  logic [ltkm_pkg::IDX_W-1:0]      leaf_raddr;
  ltkm_pkg::leaf_rec_t             leaf_rdata;
  ltkm_pkg::loser_wr_t             loser_wr;
  logic [ltkm_pkg::NODE_W-1:0]     loser_raddr;
  logic [ltkm_pkg::IDX_W-1:0]      loser_rdata;

  logic                            load_ok;
  logic                            fill_last;
  logic                            do_store;
  ltkm_pkg::leaf_rec_t             store_q;
  logic [ltkm_pkg::IDX_W:0]        path_sum;
  logic [ltkm_pkg::NODE_W-1:0]     start_node;
  logic                            opp_sent;
  logic                            lose;
  logic                            replay_done;
  logic                            more_seeds;
  ltkm_pkg::out_beat_t             emit_beat;

  // record as stored into a leaf: exhausted runs become the end marker
  function automatic ltkm_pkg::leaf_rec_t store_rec(input ltkm_pkg::in_beat_t b);
    ltkm_pkg::leaf_rec_t r;
    if (b.run_exhausted || b.key_hash == ltkm_pkg::END_MARK) begin
      r.hash  = ltkm_pkg::END_MARK;
      r.count = '0;
      r.doc   = '0;
    end else begin
      r.hash  = b.key_hash;
      r.count = b.word_count;
      r.doc   = b.doc_id;
    end
    return r;
  endfunction

  ltkm_loser_ram u_loser (
    .clk   (clk),
    .rst   (rst),
    .wr    (loser_wr),
    .raddr (loser_raddr),
    .rdata (loser_rdata)
  );

  // leaf record store
  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    leaf_rdata <= leaf_mem[leaf_raddr];
  end

  // effective run count, clamped to 1..MAX_RUNS
  always_comb begin
    if (runs_in_use == '0) begin
      kc = ltkm_pkg::IDX_W'(1);
    end else if (int'(runs_in_use) > ltkm_pkg::MAX_RUNS) begin
      kc = ltkm_pkg::IDX_W'(ltkm_pkg::MAX_RUNS);
    end else begin
      kc = ltkm_pkg::IDX_W'(runs_in_use);
    end
  end

  assign busy       = (state != IDLE);
  assign load_ok    = ltkm_pkg::IDX_W'(cmd.run_index) < ltkm_pkg::IDX_W'(ltkm_pkg::MAX_RUNS);
  assign fill_last  = ltkm_pkg::IDX_W'(fill_cnt) == kc - ltkm_pkg::IDX_W'(1);
  assign store_q    = store_rec(cmd_q);
  assign do_store   = !is_build &&
                      (sent_flags[cur_idx] || leaf_rdata.hash != ltkm_pkg::END_MARK);
  assign path_sum   = {1'b0, cur_idx} + {1'b0, kc};
  assign start_node = path_sum[ltkm_pkg::NODE_W:1];
  assign replay_done = (issue_node == '0) && !s1_v && !s2_v;
  assign more_seeds  = is_build && (seed_idx != '0);

  // carried leaf loses to the opponent: sentinel always wins, then hash up, count down
  assign opp_sent = sent_flags[s2_idx];
  assign lose = !cur_sent &&
                (opp_sent || cur_rec.hash > leaf_rdata.hash ||
                 (cur_rec.hash == leaf_rdata.hash && cur_rec.count < leaf_rdata.count));

  // result beat from the final winner
  always_comb begin
    emit_beat = '0;
    if (!cur_sent) begin
      emit_beat.winner_run  = cur_idx[ltkm_pkg::RUN_W-1:0];
      emit_beat.winner_hash = cur_rec.hash;
      if (cur_rec.hash == ltkm_pkg::END_MARK) begin
        emit_beat.merge_done = 1'b1;
      end else begin
        emit_beat.winner_count = cur_rec.count;
        emit_beat.winner_doc   = cur_rec.doc;
      end
    end
  end

  // memory port steering
  always_comb begin
    leaf_we     = 1'b0;
    leaf_waddr  = cur_idx;
    leaf_wdata  = '0;
    leaf_raddr  = seed_idx;
    loser_wr    = '0;
    loser_raddr = '0;
    unique case (state)
      IDLE: begin
        if (start) begin
          if (cmd.op == ltkm_pkg::OP_LOAD && load_ok) begin
            leaf_we    = 1'b1;
            leaf_waddr = ltkm_pkg::IDX_W'(cmd.run_index);
            leaf_wdata = store_rec(cmd);
          end else if (cmd.op == ltkm_pkg::OP_BUILD) begin
            leaf_we    = 1'b1;
            leaf_waddr = kc;
          end
        end
      end
      FILL: begin
        loser_wr.en   = 1'b1;
        loser_wr.addr = fill_cnt;
        loser_wr.data = kc;
        leaf_raddr    = kc - ltkm_pkg::IDX_W'(1);
      end
      RD_WIN: begin
        leaf_raddr = loser_rdata;
      end
      SEED: begin
        if (do_store) begin
          leaf_we    = 1'b1;
          leaf_wdata = store_q;
        end
      end
      REPLAY: begin
        loser_raddr = issue_node;
        leaf_raddr  = loser_rdata;
        if (s2_v && lose) begin
          loser_wr.en   = 1'b1;
          loser_wr.addr = s2_node;
          loser_wr.data = cur_idx;
        end
        if (replay_done) begin
          loser_wr.en   = 1'b1;
          loser_wr.addr = '0;
          loser_wr.data = cur_idx;
          leaf_raddr    = seed_idx - ltkm_pkg::IDX_W'(1);
        end
      end
    endcase
  end

  // sequencer, sentinel flags and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      result_strobe <= 1'b0;
      sent_flags    <= '0;
      runs_in_use   <= ltkm_pkg::CFG_W'(16);
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
    end else begin
      // strobe for one cycle once the last replay has finished
      result_strobe <= (state == REPLAY) && replay_done && !more_seeds;
      if (runs_we) begin
        runs_in_use <= runs_wdata;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            priority case (cmd.op)
              ltkm_pkg::OP_LOAD: begin
                if (load_ok) begin
                  sent_flags[ltkm_pkg::IDX_W'(cmd.run_index)] <= 1'b0;
                end
              end
              ltkm_pkg::OP_BUILD: begin
                sent_flags <= ltkm_pkg::FLAG_W'(1) << kc;
                is_build   <= 1'b1;
                fill_cnt   <= '0;
                state      <= FILL;
              end
              ltkm_pkg::OP_REFILL: begin
                is_build <= 1'b0;
                state    <= RD_WIN;
              end
              default: begin
              end
            endcase
          end
        end
        FILL: begin
          fill_cnt <= fill_cnt + ltkm_pkg::NODE_W'(1);
          if (fill_last) begin
            seed_idx <= kc - ltkm_pkg::IDX_W'(1);
            cur_idx  <= kc - ltkm_pkg::IDX_W'(1);
            state    <= SEED;
          end
        end
        RD_WIN: begin
          if (loser_rdata >= kc) begin
            state <= IDLE;
          end else begin
            cur_idx <= loser_rdata;
            state   <= SEED;
          end
        end
        SEED: begin
          if (do_store) begin
            sent_flags[cur_idx] <= 1'b0;
            cur_rec             <= store_q;
            cur_sent            <= 1'b0;
          end else begin
            cur_rec  <= leaf_rdata;
            cur_sent <= sent_flags[cur_idx];
          end
          issue_node <= start_node;
          s1_v       <= 1'b0;
          s2_v       <= 1'b0;
          state      <= REPLAY;
        end
        REPLAY: begin
          // stage 1: node read
          if (issue_node != '0) begin
            s1_v       <= 1'b1;
            s1_node    <= issue_node;
            issue_node <= issue_node >> 1;
          end else begin
            s1_v <= 1'b0;
          end
          // stage 2: opponent leaf read
          s2_v    <= s1_v;
          s2_node <= s1_node;
          s2_idx  <= loser_rdata;
          // stage 3: compare, the winner moves up
          if (s2_v && lose) begin
            cur_idx  <= s2_idx;
            cur_rec  <= leaf_rdata;
            cur_sent <= opp_sent;
          end
          if (replay_done) begin
            if (more_seeds) begin
              seed_idx <= seed_idx - ltkm_pkg::IDX_W'(1);
              cur_idx  <= seed_idx - ltkm_pkg::IDX_W'(1);
              state    <= SEED;
            end else begin
              result <= emit_beat;
              state  <= IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule
